@@ hdl/phsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsc_pkg
// Shared types, codes and constants of the pursuit heading and speed
// controller.
// ----------------------------------------------------------------------------
package phsc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;

  localparam int GUARD_BITS   = 8;
  localparam int CW           = 30;
  localparam int ZW           = 24;
  localparam int PI_Q13       = 25736;
  localparam int TWO_PI_Q13   = 51472;
  localparam int INV_GAIN_Q16 = 39797;

  typedef enum logic [1:0] {
    CMD_CHASER = 2'd0,
    CMD_TARGET = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_TIMEOUT = 3'd0,
    CFG_ALIGN   = 3'd1,
    CFG_SLOW    = 3'd2,
    CFG_MAX     = 3'd3,
    CFG_DGAIN   = 3'd4,
    CFG_TGAIN   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_POST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } cordic_ctl_t;

  function automatic logic [ZW-1:0] atan_q20(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0:  r = 24'd823550;
      5'd1:  r = 24'd486170;
      5'd2:  r = 24'd256879;
      5'd3:  r = 24'd130396;
      5'd4:  r = 24'd65451;
      5'd5:  r = 24'd32757;
      5'd6:  r = 24'd16383;
      5'd7:  r = 24'd8192;
      5'd8:  r = 24'd4096;
      5'd9:  r = 24'd2048;
      5'd10: r = 24'd1024;
      5'd11: r = 24'd512;
      5'd12: r = 24'd256;
      5'd13: r = 24'd128;
      5'd14: r = 24'd64;
      5'd15: r = 24'd32;
      5'd16: r = 24'd16;
      5'd17: r = 24'd8;
      5'd18: r = 24'd4;
      5'd19: r = 24'd2;
      5'd20: r = 24'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/phsc_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsc_cordic
// Iterative CORDIC vectoring unit, one micro-rotation per cycle, giving the
// unscaled magnitude and the angle in Q20.
// ----------------------------------------------------------------------------
module phsc_cordic #(
  parameter int CORDIC_STEPS = phsc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  phsc_pkg::cordic_ctl_t       ctl_in,
  input  logic signed [16:0]          dx,
  input  logic signed [16:0]          dy,
  output phsc_pkg::cordic_ctl_t       ctl_out,
  output logic signed [phsc_pkg::CW-1:0] mag,
  output logic signed [phsc_pkg::ZW-1:0] ang
);
  import phsc_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [4:0]           i_r, i_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic signed [CW-1:0] x0, y0, xs, ys;

  always_comb begin
    x0 = CW'(dx) <<< GUARD_BITS;
    y0 = CW'(dy) <<< GUARD_BITS;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl_in.start) begin
      busy_nxt = 1'b1;
      i_nxt = '0;
      if (x0 < 0) begin
        if (y0 >= 0) begin
          x_nxt = y0; y_nxt = -x0; z_nxt = ZW'(2 * 823550);
        end else begin
          x_nxt = -y0; y_nxt = x0; z_nxt = -ZW'(2 * 823550);
        end
      end else begin
        x_nxt = x0; y_nxt = y0; z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_q20(i_r);
      end else if (y_r < 0) begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_q20(i_r);
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(NSTEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign ctl_out.start = busy_r;
  assign ctl_out.done  = done_r;
  assign mag = x_r;
  assign ang = z_r;

endmodule

@@ hdl/pursuit_heading_speed_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pursuit_heading_speed_controller
// Pose store, CORDIC vectoring and proportional speed and turn law.
// A tick with a result runs through ST_CORDIC, ST_MUL, ST_POST and ST_OUT.
// No new tick is taken while one is in the serial CORDIC or a result waits.
// A pose update is registered when accepted; a timed-out tick goes to ST_OUT.
// Synchronous active-low reset clears poses, flags, age and loads registers.
// ----------------------------------------------------------------------------
module pursuit_heading_speed_controller #(
  parameter int CORDIC_STEPS = phsc_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = phsc_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [12:0]        out_linear_speed,
  output logic signed [15:0] out_angular_rate,
  output logic               out_target_lost,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  import phsc_pkg::*;

  localparam int CWD = (COORD_BITS < 16) ? COORD_BITS : 16;

  state_t state_r, state_nxt;
  logic [7:0]  tmo_r;
  logic [14:0] align_r;
  logic [12:0] slow_r, max_r, dgain_r, tgain_r;
  logic signed [15:0] cx_r, cy_r, ch_r, tx_r, ty_r;
  logic ck_r, tk_r;
  logic [7:0] age_r, age_inc;
  logic signed [16:0] dx_w, dy_w;
  cordic_ctl_t cst, cout;
  logic signed [CW-1:0] mag;
  logic signed [ZW-1:0] ang;
  logic [16:0] dprod_r;
  logic signed [17:0] err_r;
  logic signed [17:0] err_w, bear_w;
  logic [12:0] lin_r, lin_nxt;
  logic signed [15:0] angr_r;
  logic lost_r;
  logic signed [31:0] aprod;
  logic signed [18:0] ashift;
  logic [30:0] lprod;
  logic [20:0] lval;
  logic [16:0] aerr;
  logic signed [15:0] px, py;

  assign px = 16'(signed'(in_pos_x[CWD-1:0]));
  assign py = 16'(signed'(in_pos_y[CWD-1:0]));
  assign age_inc = (age_r == 8'd255) ? age_r : age_r + 8'd1;
  assign in_stall = (state_r != ST_IDLE) || (out_valid && out_stall);
  assign cst.start = (state_nxt == ST_CORDIC) && (state_r == ST_IDLE);
  assign cst.done = 1'b0;
  assign dx_w = 17'(tx_r) - 17'(cx_r);
  assign dy_w = 17'(ty_r) - 17'(cy_r);

  phsc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl_in(cst), .dx(dx_w), .dy(dy_w),
    .ctl_out(cout), .mag(mag), .ang(ang)
  );

  always_comb begin
    bear_w = 18'((ang + ZW'(64)) >>> 7);
    err_w = bear_w - 18'(ch_r);
    if (err_w > 18'sd25736) err_w = err_w - 18'sd51472;
    else if (err_w <= -18'sd25736) err_w = err_w + 18'sd51472;
    aerr = err_r[17] ? 17'(-err_r) : 17'(err_r);
    lprod = 31'(dgain_r) * 31'(dprod_r) + 31'd512;
    lval = (lprod[30:10] > 21'(max_r)) ? 21'(max_r) : lprod[30:10];
    aprod = 32'(signed'({1'b0, tgain_r})) * 32'(err_r) + 32'sd4096;
    ashift = 19'(aprod >>> 13);
    lin_nxt = (aerr > 17'(align_r)) ? slow_r : lval[12:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall && in_command == CMD_TICK && ck_r && tk_r) begin
          state_nxt = (age_inc > tmo_r) ? ST_OUT : ST_CORDIC;
        end
      end
      ST_CORDIC: if (cout.done) state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_POST;
      ST_POST:   state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tmo_r <= 8'd30; align_r <= 15'd6554; slow_r <= 13'd512;
      max_r <= 13'd2048; dgain_r <= 13'd1229; tgain_r <= 13'd4096;
      cx_r <= '0; cy_r <= '0; ch_r <= '0; tx_r <= '0; ty_r <= '0;
      ck_r <= 1'b0; tk_r <= 1'b0; age_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIMEOUT: tmo_r   <= cfg_data[7:0];
          CFG_ALIGN:   align_r <= cfg_data;
          CFG_SLOW:    slow_r  <= cfg_data[12:0];
          CFG_MAX:     max_r   <= cfg_data[12:0];
          CFG_DGAIN:   dgain_r <= cfg_data[12:0];
          CFG_TGAIN:   tgain_r <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_command)
          CMD_CHASER: begin
            cx_r <= px; cy_r <= py; ch_r <= in_heading; ck_r <= 1'b1;
          end
          CMD_TARGET: begin
            tx_r <= px; ty_r <= py; tk_r <= 1'b1; age_r <= '0;
          end
          CMD_TICK: begin
            age_r <= age_inc;
            lost_r <= 1'b1;
            lin_r <= '0;
            angr_r <= '0;
          end
          default: ;
        endcase
      end
      if (state_r == ST_CORDIC && cout.done) begin
        dprod_r <= 17'((64'(mag) * 64'(INV_GAIN_Q16) + 64'(1 << 23)) >>> 24);
        err_r <= err_w;
        lost_r <= 1'b0;
      end
      if (state_r == ST_POST) begin
        lin_r <= lin_nxt;
        angr_r <= (ashift > 19'sd32767) ? 16'sh7fff :
                  (ashift < -19'sd32768) ? 16'sh8000 : ashift[15:0];
      end
      if (state_r == ST_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  assign out_linear_speed = lin_r;
  assign out_angular_rate = angr_r;
  assign out_target_lost  = lost_r;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the pursuit heading and speed controller. A short
// table of pose updates and ticks comes first, then random phases under
// several register settings and idling patterns. Tick results are checked
// against a bit-accurate CORDIC steering predictor in the bench or fixed values.
// ----------------------------------------------------------------------------
module tb_top;
  import phsc_pkg::*;

  typedef struct {
    cmd_t              cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] h;
  } pose_item_t;

  typedef struct {
    logic [12:0]        lin;
    logic signed [15:0] ang;
    logic               lost;
  } steer_cmd_t;

  typedef enum int {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum int {CHK_MODEL, CHK_NONE, CHK_ZERO, CHK_STOP} row_check_t;

  typedef struct {
    row_kind_t  kind;
    row_check_t chk;
    pose_item_t it;
    cfg_idx_t   idx;
    int         val;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = '0;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic signed [15:0] in_heading = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [12:0]        out_linear_speed;
  logic signed [15:0] out_angular_rate;
  logic               out_target_lost;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [14:0]        cfg_data = '0;

  pursuit_heading_speed_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_heading(in_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_linear_speed(out_linear_speed), .out_angular_rate(out_angular_rate),
    .out_target_lost(out_target_lost),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state and register copies.
  longint chaser_x, chaser_y, chaser_hdg, target_x, target_y;
  bit     chaser_known, target_known;
  int     target_age;
  longint r_timeout, r_align, r_slow, r_max, r_dgain, r_tgain;

  longint atan_tab[16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                           4096, 2048, 1024, 512, 256, 128, 64, 32};

  steer_cmd_t expected_cmds[$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         ticks_sent = 0;
  int         stops_seen = 0;
  int         idle_in = 0;
  int         idle_out = 0;

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding.", expected_cmds.size());
    $display("** pursuit_heading_speed_controller: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string what, longint want, longint got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  function automatic bit steer_predict(pose_item_t it, output steer_cmd_t res);
    longint x, y, z, t, xs, ys, dist_q10, bearing, err, aerr, lin, ang;
    res = '{lin: '0, ang: '0, lost: 1'b0};
    case (it.cmd)
      CMD_CHASER: begin
        chaser_x = it.x;
        chaser_y = it.y;
        chaser_hdg = it.h;
        chaser_known = 1'b1;
        return 1'b0;
      end
      CMD_TARGET: begin
        target_x = it.x;
        target_y = it.y;
        target_known = 1'b1;
        target_age = 0;
        return 1'b0;
      end
      CMD_TICK: ;
      default: return 1'b0;
    endcase
    if (target_age < 255) target_age++;
    if (!chaser_known || !target_known) return 1'b0;
    if (target_age > r_timeout) begin
      res.lost = 1'b1;
      return 1'b1;
    end
    x = (target_x - chaser_x) * 256;
    y = (target_y - chaser_y) * 256;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 2 * atan_tab[0];
      end else begin
        t = x; x = -y; y = t; z = -2 * atan_tab[0];
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    dist_q10 = (x * INV_GAIN_Q16 + (64'sd1 <<< 23)) >>> 24;
    bearing = (z + 64) >>> 7;
    err = bearing - chaser_hdg;
    while (err > PI_Q13) err -= TWO_PI_Q13;
    while (err <= -PI_Q13) err += TWO_PI_Q13;
    aerr = (err < 0) ? -err : err;
    if (aerr > r_align) begin
      lin = r_slow;
    end else begin
      lin = (r_dgain * dist_q10 + 512) >>> 10;
      if (lin > r_max) lin = r_max;
    end
    ang = (r_tgain * err + 4096) >>> 13;
    if (ang > 32767) ang = 32767;
    if (ang < -32768) ang = -32768;
    res.lin = lin[12:0];
    res.ang = ang[15:0];
    return 1'b1;
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_out);
  end

  always @(posedge clk) begin
    steer_cmd_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_target_lost) stops_seen++;
      if (expected_cmds.size() == 0) begin
        report_mismatch("result transfers", 0, 1);
      end else begin
        e = expected_cmds.pop_front();
        if (out_linear_speed !== e.lin) report_mismatch("linear_speed", e.lin, out_linear_speed);
        if (out_angular_rate !== e.ang) report_mismatch("angular_rate", e.ang, out_angular_rate);
        if (out_target_lost !== e.lost) report_mismatch("target_lost", e.lost, out_target_lost);
      end
    end
  end

  task automatic send_item(pose_item_t it, row_check_t chk);
    steer_cmd_t res;
    bit         has;
    @(negedge clk);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_command <= it.cmd;
    in_pos_x <= it.x;
    in_pos_y <= it.y;
    in_heading <= it.h;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.cmd == CMD_TICK) ticks_sent++;
    has = steer_predict(it, res);
    case (chk)
      CHK_MODEL: if (has) expected_cmds.push_back(res);
      CHK_ZERO:  expected_cmds.push_back('{lin: 13'd0, ang: 16'sd0, lost: 1'b0});
      CHK_STOP:  expected_cmds.push_back('{lin: 13'd0, ang: 16'sd0, lost: 1'b1});
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[14:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TIMEOUT: r_timeout = val & 'hFF;
      CFG_ALIGN:   r_align = val & 'h7FFF;
      CFG_SLOW:    r_slow = val & 'h1FFF;
      CFG_MAX:     r_max = val & 'h1FFF;
      CFG_DGAIN:   r_dgain = val & 'h1FFF;
      CFG_TGAIN:   r_tgain = val & 'h1FFF;
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] rand_coord();
    if ($urandom_range(1)) return 16'($urandom);
    return $signed(16'($urandom_range(8191))) - 16'sd4096;
  endfunction

  function automatic pose_item_t rand_item();
    pose_item_t it;
    int r;
    r = $urandom_range(99);
    it.cmd = (r < 45) ? CMD_TICK : (r < 70) ? CMD_CHASER : (r < 95) ? CMD_TARGET : CMD_NONE;
    it.x = rand_coord();
    it.y = rand_coord();
    if ($urandom_range(9) == 0) it.h = 16'($urandom);
    else it.h = $signed(16'($urandom_range(51472))) - 16'sd25736;
    return it;
  endfunction

  row_t plan[$];

  function automatic row_t pose_row(cmd_t c, int x, int y, int h, row_check_t chk);
    row_t r;
    r.kind = ROW_ITEM;
    r.chk = chk;
    r.it = '{cmd: c, x: x[15:0], y: y[15:0], h: h[15:0]};
    r.idx = CFG_TIMEOUT;
    r.val = 0;
    return r;
  endfunction

  initial begin
    row_t   cfg_row;
    int     cfg_vals[6];
    r_timeout = 30; r_align = 6554; r_slow = 512; r_max = 2048;
    r_dgain = 1229; r_tgain = 4096;
    chaser_x = 0; chaser_y = 0; chaser_hdg = 0; target_x = 0; target_y = 0;
    chaser_known = 0; target_known = 0; target_age = 0;

    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_NONE));
    plan.push_back(pose_row(CMD_CHASER, 0, 0, 0, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_NONE));
    plan.push_back(pose_row(CMD_TARGET, 0, 0, 1234, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_ZERO));
    plan.push_back(pose_row(CMD_TARGET, 1024, 0, 0, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_MODEL));
    plan.push_back(pose_row(CMD_TARGET, -1024, 512, 0, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_MODEL));
    plan.push_back(pose_row(CMD_TARGET, -1024, -512, 0, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_MODEL));
    plan.push_back(pose_row(CMD_CHASER, -32768, -32768, 25736, CHK_NONE));
    plan.push_back(pose_row(CMD_TARGET, 32767, 32767, -1, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_MODEL));
    plan.push_back(pose_row(CMD_CHASER, 32767, 32767, -32768, CHK_NONE));
    plan.push_back(pose_row(CMD_TARGET, -32768, -32768, 0, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_MODEL));
    plan.push_back(pose_row(CMD_CHASER, 0, 0, -25736, CHK_NONE));
    plan.push_back(pose_row(CMD_TARGET, 0, -2048, 0, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_MODEL));
    plan.push_back(pose_row(CMD_NONE, -1, -1, -1, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 32767, CHK_MODEL));
    cfg_row = pose_row(CMD_TICK, 0, 0, 0, CHK_NONE);
    cfg_row.kind = ROW_CFG;
    cfg_row.idx = CFG_TIMEOUT;
    plan.push_back(cfg_row);
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_STOP));
    plan.push_back(pose_row(CMD_TARGET, 5, 5, 0, CHK_NONE));
    plan.push_back(pose_row(CMD_TICK, 0, 0, 0, CHK_STOP));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    idle_in = 25;
    idle_out = 79;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].it, plan[i].chk);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      case (ph)
        0: cfg_vals = '{30, 6554, 512, 2048, 1229, 4096};
        1: cfg_vals = '{255, 32767, 8191, 8191, 8191, 8191};
        2: cfg_vals = '{0, 0, 0, 0, 0, 0};
        3: cfg_vals = '{1, 25736, 4096, 4096, 8191, 8191};
        default: cfg_vals = '{$urandom_range(12), $urandom_range(25736),
                              $urandom_range(4096), $urandom_range(4096),
                              $urandom_range(8191), $urandom_range(8191)};
      endcase
      for (int k = 0; k < 6; k++) write_reg(cfg_idx_t'(k), cfg_vals[k]);
      write_reg(cfg_idx_t'(6), $urandom);
      write_reg(cfg_idx_t'(7), $urandom);
      if (ph < 2) begin
        idle_in = 25; idle_out = 79;
      end else if (ph < 4) begin
        idle_in = 79; idle_out = 25;
      end else begin
        idle_in = 0; idle_out = 0;
      end
      repeat (175) send_item(rand_item(), CHK_MODEL);
    end

    wait_idle();
    $display("Covered %0d ticks, %0d results checked, %0d of them target-lost stops,",
             ticks_sent, results_seen, stops_seen);
    $display("over eight register settings and three idling patterns.");
    if (mismatches == 0) begin
      $display("** pursuit_heading_speed_controller: PASSED **");
    end else begin
      $display("** pursuit_heading_speed_controller: FAILED **");
    end
    $finish;
  end

endmodule

@@ pursuit_heading_speed_controller.f @@
hdl/phsc_pkg.sv
hdl/phsc_cordic.sv
hdl/pursuit_heading_speed_controller.sv
test/tb_top.sv
